@@ rtl/core/psa_pkg.sv @@
// Shared types and constants of the posterior scatter accumulator.
package psa_pkg;

  localparam int COL_W      = 7;
  localparam int MAX_COLS   = 1 << COL_W;
  localparam int SUM_W      = 32;
  localparam int PROB_W     = 16;
  localparam int CELL_AW    = 2 * COL_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [CELL_AW-1:0] cell_addr_t;
  typedef logic [SUM_W-1:0]   sum_t;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_ACCUM  = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  localparam logic CFG_LAST_COL_A = 1'b0;
  localparam logic CFG_LAST_COL_B = 1'b1;

  localparam sum_t SUM_MAX = '1;

  // Access request from the sequencer to the cell store.
  typedef struct packed {
    logic       rd_en;
    cell_addr_t rd_addr;
    logic       wr_en;
    cell_addr_t wr_addr;
    sum_t       wr_data;
  } cell_req_t;

endpackage

@@ rtl/core/posterior_scatter_accumulate.sv @@
// Top level of the posterior scatter accumulator: map stores, sequencer, result register.
//
// Loads, accumulates and read-and-clear items pass through one at a time: an item
// is taken in S_IDLE, which also reads its column maps; in S_LOOK its cell address
// is formed and checked against the column limits and the cell is read; in S_UPD
// its cell is updated and written back. No new item is taken until the last one
// has left S_UPD, which it holds while the result register is full. The pace is
// set by the read-modify-write of the 16384-cell sum memory. After reset the block
// zeroes that memory one cell a cycle and takes no item until the sweep is done;
// configuration writes are taken throughout. An accumulate that uses a map entry
// never loaded since reset gives no defined result.
module posterior_scatter_accumulate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pos_a[6:0], pos_b[13:7], map_column[20:14], prob[36:21], zero[39:37]
  input  logic [psa_pkg::IN_DATA_W-1:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // cell_sum[31:0]
  output logic [psa_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [psa_pkg::COL_W-1:0]     cfg_wdata
);
  import psa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t     state_r;
  col_t       last_col_a_r;
  col_t       last_col_b_r;

  req_type_t  req_r;
  col_t       pos_a_r;
  col_t       pos_b_r;
  col_t       map_col_r;
  logic [PROB_W-1:0] prob_r;

  col_t       map_a [MAX_COLS];
  col_t       map_b [MAX_COLS];
  col_t       map_a_q;
  col_t       map_b_q;

  cell_addr_t cell_addr_r;
  logic       cell_ok_r;

  logic       out_valid_r;
  sum_t       out_sum_r;
  status_t    out_status_r;

  logic       accept;
  logic       advance;
  logic       store_ready;
  sum_t       store_rd_data;
  cell_req_t  cell_req;
  col_t       col_a;
  col_t       col_b;
  logic [SUM_W:0] sum_wide;
  logic       sat;
  sum_t       new_sum;
  status_t    status_nxt;
  sum_t       cell_nxt;

  assign in_tready = (state_r == S_IDLE) && store_ready;
  assign accept    = in_tvalid && in_tready;
  assign advance   = (state_r == S_UPD) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_a_r <= col_t'(MAX_COLS - 1);
      last_col_b_r <= col_t'(MAX_COLS - 1);
    end else if (cfg_we) begin
      if (cfg_addr == CFG_LAST_COL_A) begin
        last_col_a_r <= cfg_wdata;
      end
      if (cfg_addr == CFG_LAST_COL_B) begin
        last_col_b_r <= cfg_wdata;
      end
    end
  end

  // Map stores: looked up on transfer, loaded when a load item retires.
  always_ff @(posedge clk) begin
    if (advance && req_r == REQ_LOAD_A) begin
      map_a[pos_a_r] <= map_col_r;
    end
    if (advance && req_r == REQ_LOAD_B) begin
      map_b[pos_b_r] <= map_col_r;
    end
    if (accept) begin
      map_a_q <= map_a[in_tdata[COL_W-1:0]];
      map_b_q <= map_b[in_tdata[2*COL_W-1:COL_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= req_type_t'(in_tuser);
      pos_a_r   <= in_tdata[COL_W-1:0];
      pos_b_r   <= in_tdata[2*COL_W-1:COL_W];
      map_col_r <= in_tdata[3*COL_W-1:2*COL_W];
      prob_r    <= in_tdata[3*COL_W+PROB_W-1:3*COL_W];
    end
  end

  // Accumulates go through the maps, reads address the cell directly.
  always_comb begin
    if (req_r == REQ_ACCUM) begin
      col_a = map_a_q;
      col_b = map_b_q;
    end else begin
      col_a = pos_a_r;
      col_b = pos_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      cell_addr_r <= {col_a, col_b};
      cell_ok_r   <= (col_a <= last_col_a_r) && (col_b <= last_col_b_r);
    end
  end

  assign sum_wide = {1'b0, store_rd_data} + {{(SUM_W+1-PROB_W){1'b0}}, prob_r};
  assign sat      = sum_wide[SUM_W];
  assign new_sum  = sat ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_comb begin
    cell_req.rd_en   = (state_r == S_LOOK);
    cell_req.rd_addr = {col_a, col_b};
    cell_req.wr_en   = advance && cell_ok_r && (req_r == REQ_ACCUM || req_r == REQ_READ);
    cell_req.wr_addr = cell_addr_r;
    cell_req.wr_data = (req_r == REQ_READ) ? '0 : new_sum;
  end

  always_comb begin
    status_nxt = STATUS_OK;
    cell_nxt   = '0;
    case (req_r)
      REQ_ACCUM: begin
        if (!cell_ok_r) begin
          status_nxt = STATUS_RANGE;
        end else if (sat) begin
          status_nxt = STATUS_SAT;
        end
      end
      REQ_READ: begin
        if (!cell_ok_r) begin
          status_nxt = STATUS_RANGE;
        end else begin
          cell_nxt = store_rd_data;
        end
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase
  end

  psa_cell_store u_cell_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cell_req),
    .rd_data (store_rd_data),
    .ready   (store_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          // Hold while the previous result has not been taken.
          if (advance) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sum_r    <= cell_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_no_item_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !store_ready |-> !in_tready)
    else $error("item taken while the cell store is still being zeroed");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_sat_has_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STATUS_SAT) |-> (out_tdata == '0))
    else $error("saturated accumulate returned a cell sum");

  a_store_write_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (store_ready && cell_req.wr_en) |=> out_tvalid)
    else $error("cell written without a result being posted");
`endif

endmodule

@@ rtl/core/psa_cell_store.sv @@
// Cell sum memory with its zeroing sweep after reset.
module psa_cell_store (
  input  logic              clk,
  input  logic              rst_n,
  input  psa_pkg::cell_req_t req,
  output psa_pkg::sum_t     rd_data,
  output logic              ready
);
  import psa_pkg::*;

  sum_t       mem [MAX_COLS*MAX_COLS];
  cell_addr_t sweep_r;
  cell_addr_t sweep_nxt;
  logic       ready_r;
  logic       ready_nxt;
  logic       wr_en;
  cell_addr_t wr_addr;
  sum_t       wr_data;

  always_comb begin
    sweep_nxt = sweep_r;
    ready_nxt = ready_r;
    if (!ready_r) begin
      sweep_nxt = sweep_r + 1'b1;
      if (sweep_r == '1) begin
        ready_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      ready_r <= 1'b0;
    end else begin
      sweep_r <= sweep_nxt;
      ready_r <= ready_nxt;
    end
  end

  // Zero one cell a cycle until the sweep is done.
  always_comb begin
    if (!ready_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else begin
      wr_en   = req.wr_en;
      wr_addr = req.wr_addr;
      wr_data = req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  assign ready = ready_r;

endmodule

@@ bench/posterior_scatter_accumulate_tb.sv @@
// Self-checking bench for the posterior scatter accumulator: directed, heavy-cell and random jobs.
module posterior_scatter_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psa_pkg::*;

  typedef logic [PROB_W-1:0] prob_t;

  typedef struct {
    sum_t    cell_sum;
    status_t status;
  } cell_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // pos_a[6:0], pos_b[13:7], map_column[20:14], prob[36:21], zero[39:37]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // req_type[1:0]
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // cell_sum[31:0]
  logic [OUT_DATA_W-1:0] out_tdata;
  // status[1:0]
  logic [1:0]            out_tuser;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_addr   = 1'b0;
  logic [COL_W-1:0]      cfg_wdata  = '0;

  // Mirror of the block state
  col_t           last_col_a;
  col_t           last_col_b;
  col_t           col_map_a [MAX_COLS];
  col_t           col_map_b [MAX_COLS];
  bit [SUM_W-1:0] cell_store [MAX_COLS*MAX_COLS];
  cell_result_t   awaited_results [$];

  // Positions and cells touched by the current job
  col_t       job_a [$];
  col_t       job_b [$];
  cell_addr_t job_cells [$];

  bit idle_on = 1'b1;
  int ready_hold = 0;
  int errors = 0;
  int n_load = 0;
  int n_accum = 0;
  int n_sat = 0;
  int n_read = 0;
  int n_full_read = 0;
  int n_range = 0;
  int n_settings = 0;

  posterior_scatter_accumulate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic col_t rand_col();
    return col_t'($urandom_range(MAX_COLS - 1, 0));
  endfunction

  // Mostly a column within the limit, now and then anywhere
  function automatic col_t draw_column(col_t last);
    if ($urandom_range(9, 0) < 8) return col_t'($urandom_range(last, 0));
    return rand_col();
  endfunction

  function automatic prob_t draw_prob();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return prob_t'($urandom);
    endcase
  endfunction

  function automatic col_t draw_limit();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return '1;
      2: return col_t'($urandom_range(15, 1));
      default: return rand_col();
    endcase
  endfunction

  function automatic void predict_cell_result(req_type_t kind, col_t pa, col_t pb,
                                              col_t mcol, prob_t prob);
    cell_result_t res;
    col_t         ca;
    col_t         cb;
    cell_addr_t   addr;
    bit [SUM_W:0] total;
    res.cell_sum = '0;
    res.status   = STATUS_OK;
    case (kind)
      REQ_LOAD_A: begin
        col_map_a[pa] = mcol;
        n_load++;
      end
      REQ_LOAD_B: begin
        col_map_b[pb] = mcol;
        n_load++;
      end
      REQ_ACCUM: begin
        n_accum++;
        ca = col_map_a[pa];
        cb = col_map_b[pb];
        if (ca > last_col_a || cb > last_col_b) begin
          res.status = STATUS_RANGE;
          n_range++;
        end else begin
          addr  = {ca, cb};
          total = {1'b0, cell_store[addr]} + {{(SUM_W + 1 - PROB_W){1'b0}}, prob};
          if (total > {1'b0, SUM_MAX}) begin
            total      = {1'b0, SUM_MAX};
            res.status = STATUS_SAT;
            n_sat++;
          end
          cell_store[addr] = total[SUM_W-1:0];
        end
      end
      default: begin
        n_read++;
        if (pa > last_col_a || pb > last_col_b) begin
          res.status = STATUS_RANGE;
          n_range++;
        end else begin
          addr             = {pa, pb};
          res.cell_sum     = cell_store[addr];
          cell_store[addr] = '0;
          if (res.cell_sum != '0) n_full_read++;
        end
      end
    endcase
    awaited_results.push_back(res);
  endfunction

  task automatic send_request(req_type_t kind, col_t pa, col_t pb, col_t mcol, prob_t prob);
    int gap;
    gap = idle_on ? $urandom_range(5, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, prob, mcol, pb, pa};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cell_result(kind, pa, pb, mcol, prob);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, col_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    if (addr == CFG_LAST_COL_A) last_col_a = value;
    else last_col_b = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Change the column limits only once the pipeline is empty
  task automatic set_columns(col_t last_a, col_t last_b);
    drain_results();
    write_reg(CFG_LAST_COL_A, last_a);
    write_reg(CFG_LAST_COL_B, last_b);
    n_settings++;
  endtask

  task automatic send_noise();
    case ($urandom_range(2, 0))
      0: send_request(REQ_LOAD_A, rand_col(), rand_col(), rand_col(), prob_t'($urandom));
      1: send_request(REQ_LOAD_B, rand_col(), rand_col(), rand_col(), prob_t'($urandom));
      default: send_request(REQ_READ, rand_col(), rand_col(), rand_col(), prob_t'($urandom));
    endcase
  endtask

  task automatic test_directed();
    set_columns(7'd127, 7'd127);
    send_request(REQ_LOAD_A, 7'd0,   7'd55,  7'd0,   16'h0000);
    send_request(REQ_LOAD_A, 7'd127, 7'd0,   7'd127, 16'hFFFF);
    send_request(REQ_LOAD_A, 7'd5,   7'd127, 7'd3,   16'h5A5A);
    send_request(REQ_LOAD_B, 7'd127, 7'd0,   7'd127, 16'hA5A5);
    send_request(REQ_LOAD_B, 7'd0,   7'd127, 7'd0,   16'h0000);
    send_request(REQ_LOAD_B, 7'd31,  7'd9,   7'd3,   16'hFFFF);
    send_request(REQ_ACCUM,  7'd0,   7'd0,   7'd127, 16'hFFFF);
    send_request(REQ_ACCUM,  7'd127, 7'd127, 7'd0,   16'h0000);
    send_request(REQ_ACCUM,  7'd5,   7'd9,   7'd64,  16'h0001);
    send_request(REQ_ACCUM,  7'd5,   7'd9,   7'd1,   16'h8000);
    send_request(REQ_READ,   7'd0,   7'd127, 7'd127, 16'hFFFF);
    // Second read of the same cell must see it cleared
    send_request(REQ_READ,   7'd0,   7'd127, 7'd0,   16'h0000);
    send_request(REQ_READ,   7'd3,   7'd3,   7'd0,   16'h0000);
    send_request(REQ_READ,   7'd127, 7'd0,   7'd0,   16'h0000);
    send_request(REQ_READ,   7'd127, 7'd127, 7'd0,   16'h0000);
    // Tightest limits: only cell (0,0) is reachable
    set_columns(7'd0, 7'd0);
    send_request(REQ_ACCUM,  7'd127, 7'd127, 7'd0,   16'h1111);
    send_request(REQ_ACCUM,  7'd0,   7'd127, 7'd0,   16'h1234);
    send_request(REQ_READ,   7'd0,   7'd0,   7'd0,   16'h0000);
    send_request(REQ_READ,   7'd1,   7'd0,   7'd0,   16'h0000);
    send_request(REQ_READ,   7'd0,   7'd1,   7'd0,   16'h0000);
    send_request(REQ_READ,   7'd127, 7'd127, 7'd0,   16'h0000);
    set_columns(7'd127, 7'd127);
  endtask

  // Pile full-scale probabilities onto one cell well past 16 bits, without idling
  task automatic test_heavy_cell();
    idle_on = 1'b0;
    send_request(REQ_LOAD_A, 7'd1, 7'd0, 7'd2, 16'h0000);
    send_request(REQ_LOAD_B, 7'd0, 7'd2, 7'd1, 16'h0000);
    send_request(REQ_READ,   7'd2, 7'd1, 7'd0, 16'h0000);
    repeat (100) send_request(REQ_ACCUM, 7'd1, 7'd2, 7'd0, 16'hFFFF);
    send_request(REQ_READ,   7'd2, 7'd1, 7'd0, 16'h0000);
    send_request(REQ_READ,   7'd2, 7'd1, 7'd0, 16'h0000);
    drain_results();
    idle_on = 1'b1;
  endtask

  // One job: load both maps, scatter probabilities, read back and clear
  task automatic run_job(ref int sent);
    int   n_map;
    int   n_acc;
    int   n_rd;
    col_t pa;
    col_t pb;
    job_a.delete();
    job_b.delete();
    job_cells.delete();
    n_map = $urandom_range(12, 1);
    repeat (n_map) begin
      pa = rand_col();
      job_a.push_back(pa);
      send_request(REQ_LOAD_A, pa, rand_col(), draw_column(last_col_a), prob_t'($urandom));
      pb = rand_col();
      job_b.push_back(pb);
      send_request(REQ_LOAD_B, rand_col(), pb, draw_column(last_col_b), prob_t'($urandom));
      sent += 2;
    end
    n_acc = $urandom_range(40, 5);
    repeat (n_acc) begin
      if ($urandom_range(9, 0) == 0) begin
        send_noise();
      end else begin
        pa = job_a[$urandom_range(job_a.size() - 1, 0)];
        pb = job_b[$urandom_range(job_b.size() - 1, 0)];
        send_request(REQ_ACCUM, pa, pb, rand_col(), draw_prob());
        job_cells.push_back({col_map_a[pa], col_map_b[pb]});
      end
      sent++;
    end
    n_rd = job_cells.size() + 3;
    repeat (n_rd) begin
      if (job_cells.size() != 0 && $urandom_range(4, 0) != 0) begin
        {pa, pb} = job_cells[$urandom_range(job_cells.size() - 1, 0)];
      end else begin
        pa = rand_col();
        pb = rand_col();
      end
      send_request(REQ_READ, pa, pb, rand_col(), prob_t'($urandom));
      sent++;
    end
  endtask

  task automatic test_random(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      set_columns(draw_limit(), draw_limit());
      idle_on = ($urandom_range(3, 0) != 0);
      repeat (3) run_job(sent);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected transfer, cell_sum %h status %0d",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata !== want.cell_sum) begin
          $display("%0t: cell_sum mismatch, expected %h actual %h",
                   $time, want.cell_sum, out_tdata);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, out_tuser);
          errors++;
        end
      end
      ready_hold = idle_on ? $urandom_range(5, 0) : 0;
    end
  end

  // Hold off the result channel until the drawn hold has run out
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    last_col_a = '1;
    last_col_b = '1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_heavy_cell();
    test_random(1000);
    drain_results();
    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      errors++;
    end
    $display("Covered %0d map loads, %0d accumulates (%0d saturating), %0d reads (%0d non-zero)",
             n_load, n_accum, n_sat, n_read, n_full_read);
    $display("%0d out-of-range rejections over %0d column-limit settings, %0d errors",
             n_range, n_settings, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
